// File: hdl/cqs_pkg.sv
// ----------------------------------------------------------------------------
// cqs_pkg
// Shared constants, codes and types of the circular queue with search.
// ----------------------------------------------------------------------------
package cqs_pkg;

  localparam int unsigned DEPTH  = 8;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned OCC_W  = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W  = 3;

  typedef enum logic [1:0] {
    CMD_ENQ    = 2'd0,
    CMD_DEQ    = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic              shift;    // every cell takes its neighbor's word
    logic              wr;       // write wr_data into cell wr_slot
    logic [IDX_W-1:0]  wr_slot;
    logic [WORD_W-1:0] wr_data;
  } cell_ctl_t;

endpackage

// File: hdl/cqs_cell.sv
// ----------------------------------------------------------------------------
// cqs_cell
// One storage cell: holds a word, loads its neighbor on shift, or a new word.
// ----------------------------------------------------------------------------
module cqs_cell (
  input  logic                                clk_i,
  input  cqs_pkg::cell_ctl_t                  ctl_i,
  input  logic [cqs_pkg::IDX_W-1:0]           slot_i,
  input  logic signed [cqs_pkg::WORD_W-1:0]   nbr_i,
  output logic signed [cqs_pkg::WORD_W-1:0]   word_o
);

  logic signed [cqs_pkg::WORD_W-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    if (ctl_i.shift) begin
      word_d = nbr_i;
    end else if (ctl_i.wr && (ctl_i.wr_slot == slot_i)) begin
      word_d = ctl_i.wr_data;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// File: hdl/cqs_chain.sv
// ----------------------------------------------------------------------------
// cqs_chain
// Ring of cells; cell 0 is the queue head, a shift rotates toward the head.
// ----------------------------------------------------------------------------
module cqs_chain (
  input  logic                                clk_i,
  input  cqs_pkg::cell_ctl_t                  ctl_i,
  output logic signed [cqs_pkg::WORD_W-1:0]   head_o
);

  logic signed [cqs_pkg::WORD_W-1:0] word [cqs_pkg::DEPTH];

  for (genvar i = 0; i < cqs_pkg::DEPTH; i++) begin : g_cell
    cqs_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl_i),
      .slot_i (cqs_pkg::IDX_W'(i)),
      .nbr_i  (word[(i + 1) % cqs_pkg::DEPTH]),
      .word_o (word[i])
    );
  end

  assign head_o = word[0];

endmodule

// File: hdl/circular_queue_with_search.sv
// ----------------------------------------------------------------------------
// circular_queue_with_search
// FIFO of signed 32-bit words with enqueue, dequeue, search and list.
// ----------------------------------------------------------------------------
// The queue is a ring of DEPTH cells whose cell 0 holds the head when idle;
// entries sit in cells 0..count-1 in order. Enqueue writes the cell at the
// fill count and dequeue rotates the ring by one; both return one result.
// Search and list rotate the whole ring through DEPTH steps, one per cycle
// while no result is stalled, looking at the head cell each step; after
// DEPTH steps the ring is back in place. A search or list holds the input
// until its walk ends; a list gives one result per stored entry, head first.
// Empty search or list answers with one empty result at once. A new item is
// taken in the cycle the previous result leaves the output register; a
// stalled result stalls the input, and so does a search or list walk.
// Results carry last = 1 on the final one of each item.
// ----------------------------------------------------------------------------
module circular_queue_with_search (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic signed [cqs_pkg::WORD_W-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic signed [cqs_pkg::WORD_W-1:0]   data_o,
  output logic [cqs_pkg::POS_W-1:0]           position_o,
  output logic                                last_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  localparam logic [cqs_pkg::OCC_W-1:0] OCC_FULL = cqs_pkg::OCC_W'(cqs_pkg::DEPTH);
  localparam logic [cqs_pkg::IDX_W-1:0] STEP_END = cqs_pkg::IDX_W'(cqs_pkg::DEPTH - 1);

  logic                              state_q, state_d;
  logic [cqs_pkg::OCC_W-1:0]         occ_q, occ_d;
  logic                              list_q, list_d;
  logic signed [cqs_pkg::WORD_W-1:0] key_q, key_d;
  logic [cqs_pkg::IDX_W-1:0]         step_q, step_d;
  logic                              hit_q, hit_d;
  logic [cqs_pkg::IDX_W-1:0]         hit_pos_q, hit_pos_d;

  logic                              out_valid_q, out_valid_d;
  logic [1:0]                        status_q, status_d;
  logic signed [cqs_pkg::WORD_W-1:0] data_q, data_d;
  logic [cqs_pkg::POS_W-1:0]         pos_q, pos_d;
  logic                              last_q, last_d;

  cqs_pkg::cell_ctl_t                ctl;
  logic signed [cqs_pkg::WORD_W-1:0] head;

  logic out_free, in_acc, empty, full, in_range, match;
  logic emit_list, emit_search, advance;

  cqs_chain u_chain (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .head_o (head)
  );

  // output slot free this cycle if empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign empty    = (occ_q == '0);
  assign full     = (occ_q == OCC_FULL);
  assign in_range = (cqs_pkg::OCC_W'(step_q) < occ_q);
  assign match    = in_range && !hit_q && (head == key_q);

  // walk steps that emit a result must wait for the output slot
  assign emit_list   = (state_q == S_WALK) && list_q && in_range;
  assign emit_search = (state_q == S_WALK) && !list_q && (step_q == STEP_END);
  assign advance     = (state_q == S_WALK) && ((emit_list || emit_search) ? out_free : 1'b1);

  always_comb begin
    ctl.shift   = advance ||
                  (in_acc && (command_i == cqs_pkg::CMD_DEQ) && !empty);
    ctl.wr      = in_acc && (command_i == cqs_pkg::CMD_ENQ) && !full;
    ctl.wr_slot = occ_q[cqs_pkg::IDX_W-1:0];
    ctl.wr_data = value_i;
  end

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    list_d      = list_q;
    key_d       = key_q;
    step_d      = step_q;
    hit_d       = hit_q;
    hit_pos_d   = hit_pos_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    data_d      = data_q;
    pos_d       = pos_q;
    last_d      = last_q;

    if (in_acc) begin
      out_valid_d = 1'b1;
      data_d      = '0;
      pos_d       = '0;
      last_d      = 1'b1;
      case (command_i)
        cqs_pkg::CMD_ENQ: begin
          status_d = full ? cqs_pkg::ST_FULL : cqs_pkg::ST_OK;
          if (!full) occ_d = occ_q + cqs_pkg::OCC_W'(1);
        end
        cqs_pkg::CMD_DEQ: begin
          status_d = empty ? cqs_pkg::ST_EMPTY : cqs_pkg::ST_OK;
          if (!empty) begin
            data_d = head;
            occ_d  = occ_q - cqs_pkg::OCC_W'(1);
          end
        end
        default: begin
          // search or list
          status_d = cqs_pkg::ST_EMPTY;
          if (!empty) begin
            out_valid_d = 1'b0;
            state_d     = S_WALK;
            list_d      = (command_i == cqs_pkg::CMD_LIST);
            key_d       = value_i;
            step_d      = '0;
            hit_d       = 1'b0;
          end
        end
      endcase
    end

    if (advance) begin
      step_d = step_q + cqs_pkg::IDX_W'(1);
      if (match) begin
        hit_d     = 1'b1;
        hit_pos_d = step_q;
      end
      if (step_q == STEP_END) state_d = S_IDLE;
      if (emit_list) begin
        out_valid_d = 1'b1;
        status_d    = cqs_pkg::ST_OK;
        data_d      = head;
        pos_d       = cqs_pkg::POS_W'(step_q);
        last_d      = ((cqs_pkg::OCC_W'(step_q) + cqs_pkg::OCC_W'(1)) == occ_q);
      end
      if (emit_search) begin
        out_valid_d = 1'b1;
        data_d      = '0;
        last_d      = 1'b1;
        if (hit_q || match) begin
          status_d = cqs_pkg::ST_OK;
          pos_d    = cqs_pkg::POS_W'(hit_q ? hit_pos_q : step_q);
        end else begin
          status_d = cqs_pkg::ST_NOTFOUND;
          pos_d    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      step_q      <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      step_q      <= step_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    list_q    <= list_d;
    key_q     <= key_d;
    hit_pos_q <= hit_pos_d;
    status_q  <= status_d;
    data_q    <= data_d;
    pos_q     <= pos_d;
    last_q    <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_o      = data_q;
  assign position_o  = pos_q;
  assign last_o      = last_q;

  // count never passes the ring size
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_FULL)
    else $error("queue count above depth");

  // a walk leaves the count alone
  a_walk_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |=> (occ_q == $past(occ_q)))
    else $error("count changed during walk");

  // every walk starts at step zero
  a_walk_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) ##1 (state_q == S_WALK) |-> (step_q == '0))
    else $error("walk started mid ring");

endmodule

// File: sim/circular_queue_with_search_test.sv
// ----------------------------------------------------------------------------
// circular_queue_with_search_test
// Self-checking bench for the ring FIFO with search and list commands.
// ----------------------------------------------------------------------------
// A short scripted run walks the empty, full, wrap, duplicate-match and
// tail-match cases. A random run follows: phases that favor filling,
// draining or a mix, with search values mostly taken from stored entries.
// Every accepted item is run through a bench-side model of the ring. Each
// accepted result is checked field by field against the oldest expected one.
// Both sides idle at random, except during one quiet stretch.
// ----------------------------------------------------------------------------
module circular_queue_with_search_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 226;
  localparam int unsigned IDLE_PCT     = 22;
  localparam int unsigned QUIET_FROM   = 120;
  localparam int unsigned QUIET_TO     = 180;
  localparam int unsigned DRAIN_CYCLES = 2 * cqs_pkg::DEPTH + 4;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned SCRIPT_ROWS  = 24;

  typedef struct {
    cqs_pkg::status_e           status;
    logic [cqs_pkg::WORD_W-1:0] data;
    logic [cqs_pkg::POS_W-1:0]  pos;
    logic                       last;
  } result_t;

  // fixed = 1: single answer typed in below (data 0, position 0, last 1)
  typedef struct {
    cqs_pkg::cmd_e              cmd;
    logic [cqs_pkg::WORD_W-1:0] value;
    bit                         fixed;
    cqs_pkg::status_e           status;
  } script_row_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [1:0]                 command_i;
  logic [cqs_pkg::WORD_W-1:0] value_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [1:0]                 status_o;
  logic [cqs_pkg::WORD_W-1:0] data_o;
  logic [cqs_pkg::POS_W-1:0]  position_o;
  logic                       last_o;

  // bench copy of the ring
  logic [cqs_pkg::WORD_W-1:0] stored_words [cqs_pkg::DEPTH];
  logic [cqs_pkg::IDX_W-1:0]  head_slot;
  logic [cqs_pkg::IDX_W-1:0]  tail_slot;
  int unsigned                fill_count;

  result_t     expected_results [$];
  int unsigned error_count;
  int unsigned cycle_count;
  bit          quiet_stretch;

  script_row_t script [SCRIPT_ROWS] = '{
    '{cqs_pkg::CMD_DEQ,    32'h0000_0000, 1'b1, cqs_pkg::ST_EMPTY},  // dequeue on empty
    '{cqs_pkg::CMD_SEARCH, 32'h0000_0000, 1'b1, cqs_pkg::ST_EMPTY},  // search on empty
    '{cqs_pkg::CMD_LIST,   32'h0000_0000, 1'b1, cqs_pkg::ST_EMPTY},  // list on empty
    '{cqs_pkg::CMD_ENQ,    32'h7FFF_FFFF, 1'b0, cqs_pkg::ST_OK},
    '{cqs_pkg::CMD_DEQ,    32'h0000_0000, 1'b0, cqs_pkg::ST_OK},     // last entry out
    '{cqs_pkg::CMD_ENQ,    32'h8000_0000, 1'b0, cqs_pkg::ST_OK},
    '{cqs_pkg::CMD_ENQ,    32'hFFFF_FFFF, 1'b0, cqs_pkg::ST_OK},
    '{cqs_pkg::CMD_ENQ,    32'h0000_0000, 1'b0, cqs_pkg::ST_OK},
    '{cqs_pkg::CMD_ENQ,    32'h7FFF_FFFF, 1'b0, cqs_pkg::ST_OK},
    '{cqs_pkg::CMD_ENQ,    32'h8000_0000, 1'b0, cqs_pkg::ST_OK},     // duplicate
    '{cqs_pkg::CMD_ENQ,    32'h5555_5555, 1'b0, cqs_pkg::ST_OK},
    '{cqs_pkg::CMD_ENQ,    32'hAAAA_AAAA, 1'b0, cqs_pkg::ST_OK},
    '{cqs_pkg::CMD_ENQ,    32'h0000_0001, 1'b0, cqs_pkg::ST_OK},     // now full, tail wrapped
    '{cqs_pkg::CMD_ENQ,    32'h0000_0005, 1'b1, cqs_pkg::ST_FULL},   // dropped
    '{cqs_pkg::CMD_LIST,   32'h0000_0000, 1'b0, cqs_pkg::ST_OK},     // eight results
    '{cqs_pkg::CMD_SEARCH, 32'h8000_0000, 1'b0, cqs_pkg::ST_OK},     // nearest to head wins
    '{cqs_pkg::CMD_SEARCH, 32'h0000_0001, 1'b0, cqs_pkg::ST_OK},     // tail entry
    '{cqs_pkg::CMD_SEARCH, 32'h0000_3039, 1'b1, cqs_pkg::ST_NOTFOUND},
    '{cqs_pkg::CMD_DEQ,    32'h0000_0000, 1'b0, cqs_pkg::ST_OK},
    '{cqs_pkg::CMD_DEQ,    32'h0000_0000, 1'b0, cqs_pkg::ST_OK},
    '{cqs_pkg::CMD_ENQ,    32'h0000_0002, 1'b0, cqs_pkg::ST_OK},
    '{cqs_pkg::CMD_ENQ,    32'h0000_0003, 1'b0, cqs_pkg::ST_OK},
    '{cqs_pkg::CMD_SEARCH, 32'h0000_0003, 1'b0, cqs_pkg::ST_OK},
    '{cqs_pkg::CMD_LIST,   32'h0000_0000, 1'b0, cqs_pkg::ST_OK}
  };

  circular_queue_with_search dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_o      (data_o),
    .position_o  (position_o),
    .last_o      (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [cqs_pkg::IDX_W-1:0] ring_step(
      logic [cqs_pkg::IDX_W-1:0] slot);
    return (slot == cqs_pkg::IDX_W'(cqs_pkg::DEPTH - 1)) ?
           '0 : slot + cqs_pkg::IDX_W'(1);
  endfunction

  // Advance the bench ring by one command and queue what the block owes.
  // keep = 0 only updates the ring (the answer was typed in by hand).
  function automatic void apply_command(cqs_pkg::cmd_e cmd,
                                        logic [cqs_pkg::WORD_W-1:0] value, bit keep);
    result_t                   res;
    logic [cqs_pkg::IDX_W-1:0] slot;
    bit                        hit;
    res = '{status: cqs_pkg::ST_OK, data: '0, pos: '0, last: 1'b1};
    case (cmd)
      cqs_pkg::CMD_ENQ: begin
        if (fill_count >= cqs_pkg::DEPTH) begin
          res.status = cqs_pkg::ST_FULL;
        end else begin
          stored_words[tail_slot] = value;
          tail_slot  = ring_step(tail_slot);
          fill_count = fill_count + 1;
        end
      end
      cqs_pkg::CMD_DEQ: begin
        if (fill_count == 0) begin
          res.status = cqs_pkg::ST_EMPTY;
        end else begin
          res.data   = stored_words[head_slot];
          head_slot  = ring_step(head_slot);
          fill_count = fill_count - 1;
        end
      end
      default: begin
        if (fill_count == 0) begin
          res.status = cqs_pkg::ST_EMPTY;
        end else if (cmd == cqs_pkg::CMD_SEARCH) begin
          res.status = cqs_pkg::ST_NOTFOUND;
          hit  = 1'b0;
          slot = head_slot;
          for (int unsigned k = 0; k < fill_count; k++) begin
            if (!hit && stored_words[slot] == value) begin
              hit        = 1'b1;
              res.status = cqs_pkg::ST_OK;
              res.pos    = cqs_pkg::POS_W'(k);
            end
            slot = ring_step(slot);
          end
        end else begin
          // list: one result per entry, head first
          slot = head_slot;
          for (int unsigned k = 0; k < fill_count; k++) begin
            res.data = stored_words[slot];
            res.pos  = cqs_pkg::POS_W'(k);
            res.last = (k + 1 == fill_count);
            if (keep) expected_results.push_back(res);
            slot = ring_step(slot);
          end
          return;
        end
      end
    endcase
    if (keep) expected_results.push_back(res);
  endfunction

  // Offer one item, with random idle cycles ahead of it, and hold it until
  // the block takes it. Returns at the accepting edge.
  task automatic send_item(cqs_pkg::cmd_e cmd, logic [cqs_pkg::WORD_W-1:0] value,
                           bit keep);
    while (!quiet_stretch && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      value_i    <= $urandom;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
    apply_command(cmd, value, keep);
  endtask

  function automatic cqs_pkg::cmd_e pick_command(int unsigned mode);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (mode)
      0: return (roll < 55) ? cqs_pkg::CMD_ENQ : (roll < 70) ? cqs_pkg::CMD_DEQ :
                (roll < 90) ? cqs_pkg::CMD_SEARCH : cqs_pkg::CMD_LIST;   // filling
      1: return (roll < 15) ? cqs_pkg::CMD_ENQ : (roll < 70) ? cqs_pkg::CMD_DEQ :
                (roll < 90) ? cqs_pkg::CMD_SEARCH : cqs_pkg::CMD_LIST;   // draining
      default: return (roll < 30) ? cqs_pkg::CMD_ENQ : (roll < 60) ? cqs_pkg::CMD_DEQ :
                      (roll < 85) ? cqs_pkg::CMD_SEARCH : cqs_pkg::CMD_LIST;
    endcase
  endfunction

  function automatic logic [cqs_pkg::WORD_W-1:0] pick_value(cqs_pkg::cmd_e cmd);
    int unsigned roll;
    int unsigned off;
    roll = $urandom_range(0, 99);
    // searches mostly aim at a stored word so hits land on every position
    if (cmd == cqs_pkg::CMD_SEARCH && fill_count != 0 && roll < 60) begin
      off = $urandom_range(0, fill_count - 1);
      return stored_words[cqs_pkg::IDX_W'((int'(head_slot) + off) % cqs_pkg::DEPTH)];
    end
    if (roll < 75) return cqs_pkg::WORD_W'($urandom_range(0, 7));  // dense duplicates
    if (roll < 90) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // receiver: random stall, quiet during the stretch
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= !quiet_stretch && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("tb: unexpected result status=%0d data=%h pos=%0d last=%0b",
                   status_o, data_o, position_o, last_o);
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status || data_o !== want.data ||
            position_o !== want.pos || last_o !== want.last) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display({"tb: mismatch exp status=%0d data=%h pos=%0d last=%0b,",
                      " got status=%0d data=%h pos=%0d last=%0b"},
                     want.status, want.data, want.pos, want.last,
                     status_o, data_o, position_o, last_o);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned   mode;
    cqs_pkg::cmd_e cmd;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    command_i     = cqs_pkg::CMD_ENQ;
    value_i       = '0;
    out_stall_i   = 1'b0;
    error_count   = 0;
    cycle_count   = 0;
    quiet_stretch = 1'b0;
    for (int k = 0; k < cqs_pkg::DEPTH; k++) stored_words[k] = '0;
    head_slot  = '0;
    tail_slot  = '0;
    fill_count = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // scripted cases
    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      send_item(script[r].cmd, script[r].value, !script[r].fixed);
      if (script[r].fixed)
        expected_results.push_back('{status: script[r].status, data: '0,
                                     pos: '0, last: 1'b1});
    end

    // random run: bias is redrawn every 25 items
    mode = 2;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 25 == 0) mode = $urandom_range(0, 2);
      quiet_stretch = (n >= QUIET_FROM && n < QUIET_TO);
      cmd = pick_command(mode);
      send_item(cmd, pick_value(cmd), 1'b1);
    end
    quiet_stretch = 1'b0;
    in_valid_i <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
